// ----- src/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types and constants for the MT19937 generator block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int WORD_W       = 32;
  localparam int ADDR_W       = $clog2(STATE_WORDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam word_t MATRIX_A     = 32'h9908_B0DF;
  localparam word_t UPPER_MASK   = 32'h8000_0000;
  localparam word_t LOWER_MASK   = 32'h7FFF_FFFF;
  localparam word_t SEED_MULT    = 32'd69069;
  localparam word_t DEFAULT_SEED = 32'd4357;
  localparam word_t TEMPER_B     = 32'h9D2C_5680;
  localparam word_t TEMPER_C     = 32'hEFC6_0000;

  localparam addr_t LAST_ADDR   = addr_t'(STATE_WORDS - 1);
  localparam addr_t FAR_OFFSET  = addr_t'(TWIST_OFFSET);
  localparam addr_t FAR_WRAP    = addr_t'(STATE_WORDS - TWIST_OFFSET);

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEED,
    S_READ,
    S_TWIST
  } fsm_state_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- src/mersenne_twister_generator_top.sv -----
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top
// MT19937 generator with its 624-word state held in a synchronous memory.
//
//   Channel  Ports                               Handshake
//   input    in_operation, in_seed_value         start && !busy
//   result   out_random_word                     out_valid, one cycle
//
// A draw steps from acceptance through S_READ, which reads the next and far
// words from the state memory, and S_TWIST, which twists and writes back,
// to the idle state that accepts the next beat. The result appears in
// the cycle after the write. A seed fills all 624 words, one per cycle through
// the 69069 multiplier, with busy high throughout. A draw before any seed runs
// that fill with seed 4357 first and then twists, all while busy stays high.
// Reset is synchronous; the receiver cannot stall, so a result is never held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_operation,
  input  wire mtg_pkg::word_t       in_seed_value,
  output logic                      out_valid,
  output mtg_pkg::word_t            out_random_word
);
  import mtg_pkg::*;

  fsm_state_t state_r, state_nxt;
  addr_t      pos_r, pos_nxt;
  addr_t      cnt_r, cnt_nxt;
  word_t      x_r, x_nxt;
  word_t      cur_r, cur_nxt;
  logic       seeded_r, seeded_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_word_r, out_word_nxt;

  ram_req_t   ram_req;
  word_t      rd_nxt_word;
  word_t      rd_far_word;
  addr_t      nxt_addr;
  addr_t      far_addr;
  word_t      mixed;
  word_t      twisted;
  word_t      tempered;
  logic       accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign nxt_addr = (pos_r == LAST_ADDR) ? '0 : pos_r + addr_t'(1);
  assign far_addr = (pos_r >= FAR_WRAP) ? pos_r - FAR_WRAP : pos_r + FAR_OFFSET;

  assign mixed   = (cur_r & UPPER_MASK) | (rd_nxt_word & LOWER_MASK);
  assign twisted = rd_far_word ^ (mixed >> 1) ^ (rd_nxt_word[0] ? MATRIX_A : '0);

  mtg_temper u_temper (
    .word_in  (twisted),
    .word_out (tempered)
  );

  mtg_state_ram u_ram (
    .clk       (clk),
    .req       (ram_req),
    .rd_data_a (rd_nxt_word),
    .rd_data_b (rd_far_word)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_SEED || !seeded_r) begin
            state_nxt = S_SEED;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_SEED: begin
        if (cnt_r == LAST_ADDR) begin
          state_nxt = pend_r ? S_READ : S_IDLE;
        end
      end
      S_READ:  state_nxt = S_TWIST;
      S_TWIST: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt         = pos_r;
    cnt_nxt         = cnt_r;
    x_nxt           = x_r;
    cur_nxt         = cur_r;
    seeded_nxt      = seeded_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = 1'b0;
    out_word_nxt    = out_word_r;
    ram_req.wr_en     = 1'b0;
    ram_req.wr_addr   = cnt_r;
    ram_req.wr_data   = x_r;
    ram_req.rd_addr_a = nxt_addr;
    ram_req.rd_addr_b = far_addr;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_operation == OP_SEED || !seeded_r)) begin
          x_nxt    = ((in_operation == OP_SEED) ? in_seed_value : DEFAULT_SEED) | 32'd1;
          cur_nxt  = x_nxt;
          cnt_nxt  = '0;
          pend_nxt = (in_operation == OP_DRAW);
        end
      end
      S_SEED: begin
        ram_req.wr_en = 1'b1;
        x_nxt         = x_r * SEED_MULT;
        cnt_nxt       = cnt_r + addr_t'(1);
        if (cnt_r == LAST_ADDR) begin
          pos_nxt    = '0;
          seeded_nxt = 1'b1;
          pend_nxt   = 1'b0;
        end
      end
      S_READ: begin
      end
      S_TWIST: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = pos_r;
        ram_req.wr_data = twisted;
        cur_nxt         = rd_nxt_word;
        pos_nxt         = nxt_addr;
        out_valid_nxt   = 1'b1;
        out_word_nxt    = tempered;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      seeded_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      seeded_r    <= seeded_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_ADDR)
    else $error("word position out of range");

  a_out_from_twist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_TWIST))
    else $error("result strobe without a twist");

  a_draw_needs_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> seeded_r)
    else $error("twist started on an unseeded state");

  a_seed_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_SEED) |=> (state_r == S_SEED && cnt_r == '0))
    else $error("seed beat did not start the fill");

endmodule

`default_nettype wire

// ----- src/mtg_state_ram.sv -----
// ----------------------------------------------------------------------------
// mtg_state_ram
// State word memory: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtg_state_ram (
  input  wire logic              clk,
  input  wire mtg_pkg::ram_req_t req,
  output mtg_pkg::word_t         rd_data_a,
  output mtg_pkg::word_t         rd_data_b
);
  import mtg_pkg::*;

  word_t mem [STATE_WORDS];
  word_t rd_a_r;
  word_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= mem[req.rd_addr_a];
    rd_b_r <= mem[req.rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

// ----- src/mtg_temper.sv -----
// ----------------------------------------------------------------------------
// mtg_temper
// Output tempering of one twisted state word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtg_temper (
  input  wire mtg_pkg::word_t word_in,
  output mtg_pkg::word_t      word_out
);
  import mtg_pkg::*;

  word_t y1;
  word_t y2;
  word_t y3;

  always_comb begin
    y1       = word_in ^ (word_in >> 11);
    y2       = y1 ^ ((y1 << 7) & TEMPER_B);
    y3       = y2 ^ ((y2 << 15) & TEMPER_C);
    word_out = y3 ^ (y3 >> 18);
  end

endmodule

`default_nettype wire

// ----- sim/mersenne_twister_generator_top_tb.sv -----
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top_tb
// Self-checking bench for the MT19937 generator. A local model keeps its own
// 624-word state, fills it on every seed beat and twists one word per draw
// beat. Each tempered word the block returns is compared with the oldest
// predicted word. Directed beats cover the first draw without a seed, even,
// zero and all-ones seeds, and back-to-back seeds. A long draw run carries
// the word position past the end of the state. Random traffic follows, with
// seeds mixed into runs of draws and random gaps between beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mersenne_twister_generator_top_tb;

  import mtg_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 640;
  localparam int PRINT_LIMIT = 40;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  logic  in_operation;
  word_t in_seed_value;
  logic  out_valid;
  word_t out_random_word;

  word_t mt_words [STATE_WORDS];
  int    mt_pos;
  bit    mt_seeded;
  word_t pending_words [$];

  int  err_count;
  int  items_sent;
  int  seed_beats;
  int  draw_beats;
  int  words_checked;
  int  idle_cycles;
  bit  no_gaps;

  mersenne_twister_generator_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void fill_state(word_t seed);
    word_t x;
    x = seed | 32'd1;
    mt_words[0] = x;
    for (int k = 1; k < STATE_WORDS; k++) begin
      x = x * SEED_MULT;
      mt_words[k] = x;
    end
    mt_pos = 0;
    mt_seeded = 1'b1;
  endfunction

  function automatic word_t temper_word(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic word_t twist_next();
    int    nx;
    int    fr;
    word_t mixed;
    word_t nw;
    nx = (mt_pos + 1) % STATE_WORDS;
    fr = (mt_pos + TWIST_OFFSET) % STATE_WORDS;
    mixed = (mt_words[mt_pos] & UPPER_MASK) | (mt_words[nx] & LOWER_MASK);
    nw = mt_words[fr] ^ (mixed >> 1) ^ (mt_words[nx][0] ? MATRIX_A : 32'd0);
    mt_words[mt_pos] = nw;
    mt_pos = nx;
    return nw;
  endfunction

  function automatic word_t pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom & 32'hFFFF_FFFE;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t want);
    if (err_count < PRINT_LIMIT)
      $display("%0t ERROR %s: got %08h, expected %08h", $time, what, got, want);
    err_count++;
  endtask

  // Drives one beat and updates the model at the edge that accepts it.
  // With no gap, start stays high from the previous beat.
  task automatic send_item(logic op, word_t seed);
    int gap;
    if ($urandom_range(0, 39) == 0) no_gaps = ~no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_seed_value <= seed;
    do @(posedge clk); while (busy);
    items_sent++;
    if (op == OP_SEED) begin
      fill_state(seed);
      seed_beats++;
    end else begin
      if (!mt_seeded) fill_state(DEFAULT_SEED);
      pending_words.push_back(temper_word(twist_next()));
      draw_beats++;
    end
  endtask

  task automatic test_draw_before_seed();
    repeat (3) send_item(OP_DRAW, $urandom);
  endtask

  task automatic test_seed_extremes();
    send_item(OP_SEED, 32'h0000_0000);
    repeat (2) send_item(OP_DRAW, $urandom);
    send_item(OP_SEED, 32'hFFFF_FFFF);
    repeat (2) send_item(OP_DRAW, $urandom);
    send_item(OP_SEED, 32'hAAAA_AAAA);
    send_item(OP_DRAW, 32'h5555_5555);
    send_item(OP_SEED, 32'h5555_5555);
    send_item(OP_DRAW, 32'hAAAA_AAAA);
    send_item(OP_SEED, 32'h8000_0000);
    send_item(OP_DRAW, 32'h0000_0000);
    send_item(OP_SEED, 32'h1234_5678);
    send_item(OP_SEED, 32'h7FFF_FFFF);
    send_item(OP_DRAW, 32'hFFFF_FFFF);
    send_item(OP_SEED, DEFAULT_SEED);
    send_item(OP_DRAW, $urandom);
  endtask

  // More than one full pass over the state, so twisted words feed later draws.
  task automatic test_long_run();
    send_item(OP_SEED, $urandom);
    repeat (STATE_WORDS + 80) send_item(OP_DRAW, $urandom);
  endtask

  task automatic test_random_mix();
    int run_len;
    while (items_sent < ITEM_TARGET) begin
      send_item(OP_SEED, pick_seed());
      run_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      repeat (run_len) send_item(OP_DRAW, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result with no draw pending", out_random_word, 32'd0);
      end else begin
        if (out_random_word !== pending_words[0])
          report_mismatch("random_word", out_random_word, pending_words[0]);
        void'(pending_words.pop_front());
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ERROR watchdog: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("mersenne_twister_generator_top_tb NOT OK");
      $finish;
    end else if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = OP_SEED;
    in_seed_value = '0;
    mt_pos        = 0;
    mt_seeded     = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    seed_beats    = 0;
    draw_beats    = 0;
    words_checked = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_draw_before_seed();
    test_seed_extremes();
    test_long_run();
    test_random_mix();

    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d seed beats and %0d draw beats; %0d words compared.",
             seed_beats, draw_beats, words_checked);
    $display("Mismatches found: %0d.", err_count);
    if (err_count == 0)
      $display("mersenne_twister_generator_top_tb OK");
    else
      $display("mersenne_twister_generator_top_tb NOT OK");
    $finish;
  end

endmodule
